/* rtl/core/thermistor_peltier_bang_bang_top_macros.svh */
// Assertion helpers for the thermistor Peltier controller.
// In synthesis builds the macros expand to nothing.
`ifndef THERMISTOR_PELTIER_BANG_BANG_TOP_MACROS_SVH
`define THERMISTOR_PELTIER_BANG_BANG_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define TPBB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TPBB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TPBB_ASSERT(lbl, clk, rst, prop, msg)
`define TPBB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* rtl/core/tpbb_pkg.sv */
package tpbb_pkg;

   // Field widths.
   localparam int ADC_W   = 10;
   localparam int MODE_W  = 2;
   localparam int PWM_W   = 8;
   localparam int TEMP_W  = 16;
   localparam int ENTRY_W = MODE_W + PWM_W;

   localparam int REQ_W = 24;
   localparam int RSP_W = 80;
   localparam int RSP_ACC_BIT  = 73;
   localparam int RSP_TRIP_BIT = 74;

   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int ADC_FULL_SCALE  = 1024;
   localparam int D_W = $clog2(ADC_FULL_SCALE + 1);

   localparam logic [PWM_W-1:0] PWM_LIMIT_RST = 8'd200;

   // Shared multiplier and subtractor widths.
   localparam int MA_W   = 17;
   localparam int MB_W   = 24;
   localparam int PROD_W = MA_W + MB_W;
   localparam int WIDE_W = PROD_W + 1;

   localparam int KNEE_CNT = 5;
   localparam int KIDX_W   = 3;
   localparam int QUO_W    = 11;
   localparam int QCNT_W   = $clog2(QUO_W);
   localparam int NUM_SHIFT = 9;

   localparam logic [MA_W-1:0] LHS_SCALE = 17'd10000;
   localparam logic [MA_W-1:0] DEN_SCALE = 17'd100000;

   localparam logic signed [TEMP_W-1:0] INVALID_TEMP = -16'sd256;
   localparam logic signed [TEMP_W-1:0] SP_OFFSET    = 16'sd768;
   localparam logic signed [TEMP_W:0]   TRIP_LIMIT   = 17'sd1280;

   typedef enum logic [MODE_W-1:0] {
      MODE_COOL   = 2'd0,
      MODE_HOT    = 2'd1,
      MODE_REBASE = 2'd2,
      MODE_STOP   = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CMD,
      ST_LHS,
      ST_KNEE,
      ST_KCMP,
      ST_XDIFF,
      ST_SLOPE,
      ST_NUM,
      ST_DEN,
      ST_DIV,
      ST_APPLY
   } tpbb_state_type;

   // Resistance knees in thousandths of the ratio, highest first.
   function automatic logic [MA_W-1:0] knee_const(input logic [KIDX_W-1:0] idx);
      logic [MA_W-1:0] k;
      unique case (idx)
         3'd0:    k = 17'd12140;
         3'd1:    k = 17'd10000;
         3'd2:    k = 17'd8282;
         3'd3:    k = 17'd7150;
         default: k = 17'd5771;
      endcase
      return k;
   endfunction

   // Segment slope in hundredths of a degree per unit of ratio.
   function automatic logic [MA_W-1:0] slope_const(input logic [1:0] seg);
      logic [MA_W-1:0] s;
      unique case (seg)
         2'd0: s = 17'd227;
         2'd1: s = 17'd279;
         2'd2: s = 17'd338;
         2'd3: s = 17'd420;
      endcase
      return s;
   endfunction

   // Segment base temperature in Q8.8.
   function automatic logic [TEMP_W-1:0] seg_base_q88(input logic [1:0] seg);
      logic [TEMP_W-1:0] b;
      unique case (seg)
         2'd0: b = 16'd5120;
         2'd1: b = 16'd6400;
         2'd2: b = 16'd7680;
         2'd3: b = 16'd8704;
      endcase
      return b;
   endfunction

endpackage

/* rtl/core/thermistor_peltier_bang_bang_top.sv */
// Thermistor-driven Peltier bang-bang controller.
// Input stream (req_): one beat is either a thermistor sample (tuser 0) or a
// mode command (tuser 1). Output stream (rsp_): exactly one result beat per
// input beat, in order. The csr_ channel writes the pwm limit and is always
// ready; write it only while the block is idle.
// A command beat is finished in ST_CMD once the output slot is free: its pwm is
// checked against the limit and it is queued if the command queue has room.
// For a sample beat, one shared multiplier and one shared subtractor work
// through the resistance ratio, the segment knees (a product state and a
// compare state per knee, up to five knees) and an 11-step restoring divider
// that rounds the segment offset; a reading out of range goes straight to
// ST_APPLY, where the controller update runs.
// Only one beat is in work at a time; req_tready is high while idle, so the
// next beat can be accepted in the same cycle that a result appears. A
// finished result sits in the output register; when the receiver stalls, the
// next beat is still accepted and its work stalls at the final step until
// the slot frees.
// Reset clears the drive outputs, flags and queue, sets the pwm limit to 200
// and marks the next sample as the one that sets baseline and setpoint.
module thermistor_peltier_bang_bang_top
   import tpbb_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // adc_sample [9:0], mode [11:10], pwm_value [19:12], zero fill above
   input  logic [REQ_W-1:0] req_tdata,
   // cmd [0]
   input  logic [0:0]       req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // temp_now [14:0], baseline [29:15], setpoint [45:30], delta [61:46],
   // drive_pwm [69:62], drive_dir [70], heater_on [71], heater_active [72],
   // command_accepted [73], safety_tripped [74], zero fill above
   output logic [RSP_W-1:0] rsp_tdata,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [PWM_W-1:0] csr_wdata
);

`include "thermistor_peltier_bang_bang_top_macros.svh"

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Control state.
   tpbb_state_type state_ff, state_in;
   logic                     first_ff, first_in;
   logic signed [TEMP_W-1:0] base_ff, base_in;
   logic signed [TEMP_W-1:0] target_ff, target_in;
   logic                     on_ff, on_in;
   logic                     act_ff, act_in;
   mode_type                 cur_mode_ff, cur_mode_in;
   logic [PWM_W-1:0]         level_ff, level_in;
   logic [PWM_W-1:0]         pwm_ff, pwm_in;
   logic                     dir_ff, dir_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [PTR_W-1:0]         head_ff, head_in;
   logic [PTR_W-1:0]         tail_ff, tail_in;
   logic [PWM_W-1:0]         limit_ff, limit_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [KIDX_W-1:0]        knee_ff, knee_in;
   logic [QCNT_W-1:0]        qcnt_ff, qcnt_in;

   // Datapath registers.
   logic [ADC_W-1:0]         adc_ff, adc_in;
   logic [MODE_W-1:0]        req_mode_ff, req_mode_in;
   logic [PWM_W-1:0]         req_pwm_ff, req_pwm_in;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic [WIDE_W-1:0]        lhs_ff, lhs_in;
   logic [WIDE_W-1:0]        hi_ff, hi_in;
   logic [MB_W-1:0]          x_ff, x_in;
   logic [1:0]               seg_ff, seg_in;
   logic [WIDE_W-1:0]        rem_ff, rem_in;
   logic [WIDE_W-1:0]        div_ff, div_in;
   logic [QUO_W-1:0]         quo_ff, quo_in;
   logic signed [TEMP_W-1:0] temp_ff, temp_in;
   logic [RSP_W-1:0]         rsp_data_ff, rsp_data_in;

   // Command queue.
   logic [ENTRY_W-1:0] fifo_mem [QUEUE_DEPTH];
   logic [ENTRY_W-1:0] fifo_rd_ff;
   logic               push;

   // Shared units.
   logic [MA_W-1:0]   mul_a;
   logic [MB_W-1:0]   mul_b;
   logic [WIDE_W-1:0] sub_a, sub_b;
   logic [WIDE_W:0]   sub_diff;
   logic              sub_borrow;

   logic [D_W:0]   d_wide;
   logic [D_W-1:0] d_val;
   logic           d_bad;
   logic           out_free;
   logic           acc_c;
   logic           trip_c;

   logic signed [TEMP_W-1:0] base_eff, target_eff;
   logic signed [TEMP_W:0]   delta_w;
   logic                     done_c;
   mode_type                 pop_mode;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Denominator of the resistance ratio.
   assign d_wide = (D_W+1)'(ADC_FULL_SCALE) - (D_W+1)'(adc_ff);
   assign d_bad  = d_wide[D_W] || (d_wide == '0);
   assign d_val  = d_wide[D_W-1:0];

   assign prod_in    = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_borrow = sub_diff[WIDE_W];

   always_comb begin
      state_in     = state_ff;
      first_in     = first_ff;
      base_in      = base_ff;
      target_in    = target_ff;
      on_in        = on_ff;
      act_in       = act_ff;
      cur_mode_in  = cur_mode_ff;
      level_in     = level_ff;
      pwm_in       = pwm_ff;
      dir_in       = dir_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      limit_in     = csr_valid ? csr_wdata : limit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      knee_in      = knee_ff;
      qcnt_in      = qcnt_ff;
      adc_in       = adc_ff;
      req_mode_in  = req_mode_ff;
      req_pwm_in   = req_pwm_ff;
      lhs_in       = lhs_ff;
      hi_in        = hi_ff;
      x_in         = x_ff;
      seg_in       = seg_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      quo_in       = quo_ff;
      temp_in      = temp_ff;
      rsp_data_in  = rsp_data_ff;
      mul_a        = '0;
      mul_b        = '0;
      sub_a        = '0;
      sub_b        = '0;
      push         = 1'b0;
      acc_c        = 1'b0;
      trip_c       = 1'b0;
      done_c       = 1'b0;
      pop_mode     = mode_type'(fifo_rd_ff[ENTRY_W-1:PWM_W]);

      // On the first sample the baseline and setpoint take this reading.
      base_eff   = first_ff ? temp_ff : base_ff;
      target_eff = first_ff ? temp_ff : target_ff;
      delta_w    = {temp_ff[TEMP_W-1], temp_ff} - {base_eff[TEMP_W-1], base_eff};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               adc_in      = req_tdata[ADC_W-1:0];
               req_mode_in = req_tdata[ADC_W+MODE_W-1:ADC_W];
               req_pwm_in  = req_tdata[ADC_W+MODE_W+PWM_W-1:ADC_W+MODE_W];
               state_in    = req_tuser[0] ? ST_CMD : ST_LHS;
            end
         end
         ST_CMD: begin
            acc_c = (req_pwm_ff <= limit_ff) && (count_ff != CNT_W'(QUEUE_DEPTH));
            if (out_free) begin
               push = acc_c;
               if (acc_c) begin
                  count_in = count_ff + 1'b1;
                  tail_in  = ptr_inc(tail_ff);
               end
               rsp_data_in  = {5'b0, 1'b0, acc_c, act_ff, on_ff, dir_ff, pwm_ff,
                               16'd0, target_ff, base_ff[TEMP_W-2:0], 15'd0};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_LHS: begin
            mul_a = LHS_SCALE;
            mul_b = MB_W'(adc_ff);
            if (d_bad) begin
               temp_in  = INVALID_TEMP;
               state_in = ST_APPLY;
            end else begin
               knee_in  = '0;
               state_in = ST_KNEE;
            end
         end
         ST_KNEE: begin
            // The first pass finds the ratio numerator in the product register.
            if (knee_ff == '0) begin
               lhs_in = WIDE_W'(prod_ff);
            end
            mul_a    = knee_const(knee_ff);
            mul_b    = MB_W'(d_val);
            state_in = ST_KCMP;
         end
         ST_KCMP: begin
            sub_a = WIDE_W'(prod_ff);
            sub_b = lhs_ff;
            if (sub_borrow) begin
               // The ratio lies above this knee.
               if (knee_ff == '0) begin
                  temp_in  = INVALID_TEMP;
                  state_in = ST_APPLY;
               end else begin
                  seg_in   = 2'(knee_ff - 1'b1);
                  state_in = ST_XDIFF;
               end
            end else if (knee_ff == KIDX_W'(KNEE_CNT - 1)) begin
               temp_in  = INVALID_TEMP;
               state_in = ST_APPLY;
            end else begin
               hi_in    = WIDE_W'(prod_ff);
               knee_in  = knee_ff + 1'b1;
               state_in = ST_KNEE;
            end
         end
         ST_XDIFF: begin
            sub_a    = hi_ff;
            sub_b    = lhs_ff;
            x_in     = sub_diff[MB_W-1:0];
            state_in = ST_SLOPE;
         end
         ST_SLOPE: begin
            mul_a    = slope_const(seg_ff);
            mul_b    = x_ff;
            state_in = ST_NUM;
         end
         ST_NUM: begin
            rem_in   = WIDE_W'(prod_ff) << NUM_SHIFT;
            mul_a    = DEN_SCALE;
            mul_b    = MB_W'(d_val);
            state_in = ST_DEN;
         end
         ST_DEN: begin
            // Adding half the divisor makes the truncating divide round.
            rem_in   = rem_ff + WIDE_W'(prod_ff);
            div_in   = WIDE_W'(prod_ff) << QUO_W;
            quo_in   = '0;
            qcnt_in  = QCNT_W'(QUO_W - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            sub_a  = rem_ff;
            sub_b  = div_ff;
            quo_in = {quo_ff[QUO_W-2:0], !sub_borrow};
            if (!sub_borrow) begin
               rem_in = sub_diff[WIDE_W-1:0];
            end
            div_in = div_ff >> 1;
            if (qcnt_ff == '0) begin
               temp_in  = $signed(seg_base_q88(seg_ff) + TEMP_W'(quo_in));
               state_in = ST_APPLY;
            end else begin
               qcnt_in = qcnt_ff - 1'b1;
            end
         end
         ST_APPLY: begin
            trip_c = on_ff && ((delta_w > TRIP_LIMIT) || (delta_w < -TRIP_LIMIT) ||
                               (temp_ff == INVALID_TEMP));
            first_in  = 1'b0;
            base_in   = base_eff;
            target_in = target_eff;
            if (trip_c) begin
               pwm_in   = '0;
               on_in    = 1'b0;
               act_in   = 1'b0;
               count_in = '0;
               tail_in  = head_ff;
            end else begin
               if (count_ff != '0) begin
                  head_in     = ptr_inc(head_ff);
                  count_in    = count_ff - 1'b1;
                  cur_mode_in = pop_mode;
                  level_in    = fifo_rd_ff[PWM_W-1:0];
                  unique case (pop_mode)
                     MODE_HOT: begin
                        target_in = base_eff + SP_OFFSET;
                        act_in    = 1'b1;
                        on_in     = 1'b1;
                     end
                     MODE_COOL: begin
                        target_in = base_eff - SP_OFFSET;
                        act_in    = 1'b1;
                        on_in     = 1'b1;
                     end
                     MODE_REBASE: begin
                        base_in = temp_ff;
                        act_in  = 1'b0;
                        on_in   = 1'b0;
                        done_c  = 1'b1;
                     end
                     MODE_STOP: begin
                        pwm_in = '0;
                        act_in = 1'b0;
                        on_in  = 1'b0;
                        done_c = 1'b1;
                     end
                  endcase
               end
               if (!done_c && act_in) begin
                  if (cur_mode_in == MODE_COOL) begin
                     if (temp_ff < target_in) begin
                        pwm_in = '0;
                     end else begin
                        dir_in = 1'b0;
                        pwm_in = level_in;
                     end
                  end else begin
                     if (temp_ff > target_in) begin
                        pwm_in = '0;
                     end else begin
                        dir_in = 1'b1;
                        pwm_in = level_in;
                     end
                  end
               end
            end
            rsp_data_in = {5'b0, trip_c, 1'b0, act_ff, on_ff, dir_in, pwm_in,
                           delta_w[TEMP_W-1:0], target_in, base_in[TEMP_W-2:0],
                           temp_ff[TEMP_W-2:0]};
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               // Hold all state until the output slot frees.
               first_in    = first_ff;
               base_in     = base_ff;
               target_in   = target_ff;
               on_in       = on_ff;
               act_in      = act_ff;
               cur_mode_in = cur_mode_ff;
               level_in    = level_ff;
               pwm_in      = pwm_ff;
               dir_in      = dir_ff;
               count_in    = count_ff;
               head_in     = head_ff;
               tail_in     = tail_ff;
               rsp_data_in = rsp_data_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         first_ff     <= 1'b1;
         base_ff      <= '0;
         target_ff    <= '0;
         on_ff        <= 1'b0;
         act_ff       <= 1'b0;
         cur_mode_ff  <= MODE_COOL;
         level_ff     <= '0;
         pwm_ff       <= '0;
         dir_ff       <= 1'b0;
         count_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         limit_ff     <= PWM_LIMIT_RST;
         rsp_valid_ff <= 1'b0;
         knee_ff      <= '0;
         qcnt_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         base_ff      <= base_in;
         target_ff    <= target_in;
         on_ff        <= on_in;
         act_ff       <= act_in;
         cur_mode_ff  <= cur_mode_in;
         level_ff     <= level_in;
         pwm_ff       <= pwm_in;
         dir_ff       <= dir_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
         knee_ff      <= knee_in;
         qcnt_ff      <= qcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      adc_ff      <= adc_in;
      req_mode_ff <= req_mode_in;
      req_pwm_ff  <= req_pwm_in;
      prod_ff     <= prod_in;
      lhs_ff      <= lhs_in;
      hi_ff       <= hi_in;
      x_ff        <= x_in;
      seg_ff      <= seg_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      quo_ff      <= quo_in;
      temp_ff     <= temp_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Queue storage: one write port at the tail, registered read at the head.
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[tail_ff] <= {req_mode_ff, req_pwm_ff};
      end
      fifo_rd_ff <= fifo_mem[head_ff];
   end

   `TPBB_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(QUEUE_DEPTH), "queue count over depth")
   `TPBB_ASSERT(a_empty_ptrs, clock, reset, (count_ff == '0) |-> (tail_ff == head_ff), "empty queue pointers differ")
   `TPBB_ASSERT(a_trip_flush, clock, reset, (state_ff == ST_APPLY && out_free && trip_c) |=> (count_ff == '0 && !on_ff && pwm_ff == '0), "trip did not stop drive")
   `TPBB_ASSERT(a_trip_acc_excl, clock, reset, rsp_valid_ff |-> !(rsp_data_ff[RSP_TRIP_BIT] && rsp_data_ff[RSP_ACC_BIT]), "trip and accept both set")
   `TPBB_ASSERT(a_apply_hold, clock, reset, (state_ff == ST_APPLY && !out_free) |=> (state_ff == ST_APPLY && $stable(temp_ff)), "stalled result lost")

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import tpbb_pkg::*;

   localparam int NO_READING = -256;
   localparam int DRIFT_LIMIT = 5 * 256;
   localparam int SETPOINT_STEP = 3 * 256;

   typedef struct packed {
      logic       is_cmd;
      logic [9:0] adc;
      mode_type   mode;
      logic [7:0] pwm;
   } ctl_item_t;

   // Mirrors rsp_tdata, highest bits first.
   typedef struct packed {
      logic [4:0]  spare;
      logic        safety_tripped;
      logic        command_accepted;
      logic        heater_active;
      logic        heater_on;
      logic        drive_dir;
      logic [7:0]  drive_pwm;
      logic [15:0] delta;
      logic [15:0] setpoint;
      logic [14:0] baseline;
      logic [14:0] temp_now;
   } rsp_beat_t;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic [0:0]       req_tuser = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [PWM_W-1:0] csr_wdata = '0;

   thermistor_peltier_bang_bang_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Controller state as the block should hold it.
   logic [7:0]  pwm_limit_q = PWM_LIMIT_RST;
   bit          first_q = 1'b1;
   int          base_q = 0;
   int          target_q = 0;
   bit          on_q = 1'b0;
   bit          active_q = 1'b0;
   mode_type    mode_q = MODE_COOL;
   logic [7:0]  level_q = '0;
   logic [7:0]  pwm_q = '0;
   bit          dir_q = 1'b0;
   logic [9:0]  cmd_backlog[$];

   // Ratio knees in thousandths, slopes in hundredths of a degree, bases in degrees.
   longint unsigned knee_milli [5] = '{12140, 10000, 8282, 7150, 5771};
   longint unsigned slope_centi [4] = '{227, 279, 338, 420};
   longint unsigned base_deg [4] = '{20, 25, 30, 34};

   ctl_item_t  pending_items[$];
   rsp_beat_t  expected_beats[$];
   ctl_item_t  req_item;
   int         items_queued = 0;
   int         items_sent = 0;
   int         results_seen = 0;
   int         cmds_queued = 0;
   int         trips_seen = 0;
   int         bad_count = 0;
   int         sender_gap_pct = 0;
   int         sink_stall_pct = 0;
   int         center_code = 470;

   // Resistance ratio R = 10 v / (full scale - v), compared exactly in
   // integer form, then linear interpolation on the matching segment.
   function automatic int sample_to_q88(input logic [9:0] code);
      longint signed   diff;
      longint unsigned span, lhs, num, den;
      diff = longint'(ADC_FULL_SCALE) - longint'(code);
      if (diff <= 0)
         return NO_READING;
      span = diff;
      lhs = longint'(code) * 10000;
      if (lhs > knee_milli[0] * span)
         return NO_READING;
      for (int s = 0; s < 4; s++) begin
         if (lhs > knee_milli[s + 1] * span) begin
            num = 256 * slope_centi[s] * (knee_milli[s] * span - lhs);
            den = 100000 * span;
            return int'(base_deg[s] * 256 + (2 * num + den) / (2 * den));
         end
      end
      return NO_READING;
   endfunction

   function automatic rsp_beat_t predict_control(input ctl_item_t it);
      rsp_beat_t  r;
      int         reading;
      int         drift;
      bit         hold;
      logic [9:0] slot;
      r = '0;
      reading = 0;
      drift = 0;
      hold = 1'b0;
      r.heater_on = on_q;
      r.heater_active = active_q;
      if (it.is_cmd) begin
         if (it.pwm <= pwm_limit_q && cmd_backlog.size() < QUEUE_DEPTH_DEF) begin
            cmd_backlog.push_back({it.mode, it.pwm});
            r.command_accepted = 1'b1;
         end
      end else begin
         reading = sample_to_q88(it.adc);
         if (first_q) begin
            base_q = reading;
            target_q = reading;
            first_q = 1'b0;
         end
         drift = reading - base_q;
         if ((drift > DRIFT_LIMIT || drift < -DRIFT_LIMIT || reading == NO_READING) && on_q) begin
            pwm_q = '0;
            on_q = 1'b0;
            active_q = 1'b0;
            cmd_backlog.delete();
            r.safety_tripped = 1'b1;
         end else begin
            if (cmd_backlog.size() > 0) begin
               slot = cmd_backlog.pop_front();
               mode_q = mode_type'(slot[9:8]);
               level_q = slot[7:0];
               case (mode_q)
                  MODE_HOT: begin
                     target_q = base_q + SETPOINT_STEP;
                     active_q = 1'b1;
                     on_q = 1'b1;
                  end
                  MODE_COOL: begin
                     target_q = base_q - SETPOINT_STEP;
                     active_q = 1'b1;
                     on_q = 1'b1;
                  end
                  MODE_REBASE: begin
                     base_q = reading;
                     active_q = 1'b0;
                     on_q = 1'b0;
                     hold = 1'b1;
                  end
                  default: begin
                     pwm_q = '0;
                     active_q = 1'b0;
                     on_q = 1'b0;
                     hold = 1'b1;
                  end
               endcase
            end
            // Bang-bang: drive toward the setpoint, switch off once past it.
            if (!hold && active_q) begin
               if (mode_q == MODE_COOL) begin
                  if (reading < target_q) begin
                     pwm_q = '0;
                  end else begin
                     dir_q = 1'b0;
                     pwm_q = level_q;
                  end
               end else if (reading > target_q) begin
                  pwm_q = '0;
               end else begin
                  dir_q = 1'b1;
                  pwm_q = level_q;
               end
            end
         end
      end
      r.temp_now = reading[14:0];
      r.baseline = base_q[14:0];
      r.setpoint = target_q[15:0];
      r.delta = drift[15:0];
      r.drive_pwm = pwm_q;
      r.drive_dir = dir_q;
      return r;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         bad_count++;
         if (bad_count <= 10)
            $display("%0t: result %0d field %s: expected 0x%0h, got 0x%0h",
                     $realtime, results_seen, name, want, got);
      end
   endtask

   // Sender side: present pending beats, predict each one as it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_beats.push_back(predict_control(req_item));
            items_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_items.size() > 0 && $urandom_range(0, 99) >= sender_gap_pct) begin
               req_item = pending_items.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {4'b0, req_item.pwm, req_item.mode, req_item.adc};
               req_tuser <= req_item.is_cmd;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver side: random back-pressure and field-by-field comparison.
   always @(posedge clock) begin
      rsp_beat_t got;
      rsp_beat_t want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_beat_t'(rsp_tdata);
            if (expected_beats.size() == 0) begin
               bad_count++;
               if (bad_count <= 10)
                  $display("%0t: result beat with nothing expected: 0x%0h",
                           $realtime, rsp_tdata);
            end else begin
               want = expected_beats.pop_front();
               check_field("temp_now", 32'(want.temp_now), 32'(got.temp_now));
               check_field("baseline", 32'(want.baseline), 32'(got.baseline));
               check_field("setpoint", 32'(want.setpoint), 32'(got.setpoint));
               check_field("delta", 32'(want.delta), 32'(got.delta));
               check_field("drive_pwm", 32'(want.drive_pwm), 32'(got.drive_pwm));
               check_field("drive_dir", 32'(want.drive_dir), 32'(got.drive_dir));
               check_field("heater_on", 32'(want.heater_on), 32'(got.heater_on));
               check_field("heater_active", 32'(want.heater_active),
                           32'(got.heater_active));
               check_field("command_accepted", 32'(want.command_accepted),
                           32'(got.command_accepted));
               check_field("safety_tripped", 32'(want.safety_tripped),
                           32'(got.safety_tripped));
               check_field("zero fill", 32'(want.spare), 32'(got.spare));
               if (want.command_accepted)
                  cmds_queued++;
               if (want.safety_tripped)
                  trips_seen++;
            end
            results_seen++;
         end
         rsp_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
   end

   function automatic ctl_item_t sample_item(input int code);
      ctl_item_t it;
      it.is_cmd = 1'b0;
      it.adc = code[9:0];
      it.mode = mode_type'($urandom_range(0, 3));
      it.pwm = 8'($urandom_range(0, 255));
      return it;
   endfunction

   function automatic ctl_item_t command_item(input mode_type m, input int pwm);
      ctl_item_t it;
      it.is_cmd = 1'b1;
      it.adc = 10'($urandom_range(0, 1023));
      it.mode = m;
      it.pwm = pwm[7:0];
      return it;
   endfunction

   task automatic queue_item(input ctl_item_t it);
      pending_items.push_back(it);
      items_queued++;
   endtask

   // Occasional short command bursts followed by readings mostly near a slowly
   // wandering operating point, with validity edges and arbitrary codes mixed in.
   task automatic queue_random(input int count);
      int n;
      int pick;
      int pwm;
      n = 0;
      while (n < count) begin
         if ($urandom_range(0, 99) < 35) begin
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(0, 99) < 80)
                  pwm = $urandom_range(0, pwm_limit_q);
               else
                  pwm = $urandom_range(0, 255);
               queue_item(command_item(mode_type'($urandom_range(0, 3)), pwm));
               n++;
            end
         end
         repeat ($urandom_range(1, 4)) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 5)
               center_code = $urandom_range(380, 555);
            if (pick < 70)
               queue_item(sample_item(center_code + $urandom_range(0, 100) - 50));
            else if (pick < 82)
               queue_item(sample_item($urandom_range(0, 1) ? $urandom_range(370, 379)
                                                          : $urandom_range(556, 566)));
            else
               queue_item(sample_item($urandom_range(0, 1023)));
            n++;
         end
      end
   endtask

   task automatic write_limit(input logic [7:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      pwm_limit_q = value;
   endtask

   task automatic settle(input int cycles);
      while (items_sent != items_queued || expected_beats.size() != 0)
         @(posedge clock);
      repeat (cycles) @(posedge clock);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      sender_gap_pct = 10;
      sink_stall_pct = 62;

      // Directed part, under the reset pwm limit of 200.
      queue_item(sample_item(0));                  // invalid first reading sets baseline
      queue_item(command_item(MODE_REBASE, 0));
      queue_item(sample_item(470));                // rebaseline to a valid reading
      queue_item(command_item(MODE_HOT, 200));     // exactly at the limit
      queue_item(command_item(MODE_COOL, 201));    // just above the limit
      queue_item(command_item(MODE_COOL, 255));
      queue_item(sample_item(470));                // heating starts
      queue_item(sample_item(1023));               // invalid while on: trip and flush
      queue_item(command_item(MODE_HOT, 10));
      queue_item(command_item(MODE_COOL, 20));
      queue_item(command_item(MODE_STOP, 0));
      queue_item(command_item(MODE_REBASE, 5));
      queue_item(command_item(MODE_HOT, 7));       // queue already full
      queue_item(sample_item(470));
      queue_item(sample_item(512));                // ratio exactly on the 10.0 knee
      queue_item(sample_item(470));
      queue_item(sample_item(561));                // highest valid code
      queue_item(sample_item(562));                // invalid while off: no trip
      queue_item(sample_item(374));
      queue_item(sample_item(375));                // lowest valid code
      queue_item(sample_item(1));
      queue_item(command_item(MODE_HOT, 0));
      queue_item(sample_item(561));
      queue_item(sample_item(470));                // large drift while on: trip
      settle(8);

      write_limit(8'd255);
      queue_random(380);
      settle(8);

      sender_gap_pct = 62;
      sink_stall_pct = 10;
      write_limit(8'd0);
      queue_random(380);
      settle(8);
      write_limit(8'd100);
      queue_random(380);
      settle(8);

      sender_gap_pct = 0;
      sink_stall_pct = 0;
      write_limit(8'd1);
      queue_random(380);
      settle(8);
      write_limit(8'd255);
      queue_random(380);
      settle(40);

      if (expected_beats.size() != 0)
         bad_count++;
      $display("testbench: %0d beats sent, %0d results checked, %0d commands queued,",
               items_sent, results_seen, cmds_queued);
      $display("testbench: %0d safety trips, pwm limits 200/255/0/100/1/255, %0d mismatches",
               trips_seen, bad_count);
      if (bad_count == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("testbench: done, errors");
      $finish;
   end

endmodule
